// ===== hw/rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator modules.
// ----------------------------------------------------------------------------
package ffba_pkg;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_REALLOC = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NOMEM   = 2'd1,
		STAT_DBLFREE = 2'd2,
		STAT_UNKNOWN = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		REG_HEADER     = 2'd0,
		REG_MIN_SPLIT  = 2'd1,
		REG_HEAP_LIMIT = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_e;

	localparam logic [6:0]  HEADER_RESET     = 7'd24;
	localparam logic [7:0]  MIN_SPLIT_RESET  = 8'd8;
	localparam logic [16:0] HEAP_LIMIT_RESET = 17'h10000;

	typedef struct packed {
		logic [1:0]  command;
		logic [16:0] request_size;
		logic [16:0] payload_address;
	} request_t;

	typedef struct packed {
		logic [16:0] result_address;
		logic [1:0]  status;
		logic [16:0] allocated_bytes;
		logic [6:0]  block_total;
	} result_t;

	typedef struct packed {
		logic [15:0] offset;
		logic [16:0] size;
		logic        is_free;
		logic [5:0]  next;
	} entry_t;

	typedef enum logic [4:0] {
		FSM_IDLE,
		FSM_DISP,
		FSM_AL_RD,
		FSM_AL_CHK,
		FSM_AL_APP,
		FSM_AL_TAIL,
		FSM_SP_CHK,
		FSM_SP_WR2,
		FSM_FD_RD,
		FSM_FD_CHK,
		FSM_FR_RD,
		FSM_FR_WR,
		FSM_CO_RDH,
		FSM_CO_GETI,
		FSM_CO_LOOP,
		FSM_CO_CHK,
		FSM_FINISH
	} fsm_e;

endpackage

// ===== hw/rtl/ffba_table.sv =====
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffba_table #(
	parameter int DEPTH = 64,
	parameter int IW    = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [IW-1:0]   waddr,
	input  ffba_pkg::entry_t wdata,
	input  logic [IW-1:0]   raddr,
	output ffba_pkg::entry_t rdata
);
	import ffba_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/first_fit_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap allocator with split and coalesce over a linked block table.
//
//   port          dir  role
//   start/busy    in   command item: taken when start is high and busy is low
//   request       in   command, size and payload address
//   done/result   out  one result item per command, one cycle, no back-pressure
//   cfg_*         in   register write: enable, index, data
//
// A command walks the table one entry at a time, each step a memory read on
// the table's single read port. A free walks the list for the lookup and
// again to coalesce; a reallocate that moves its block adds the first-fit
// search walk.
// Reset clears the list state at once; table contents need no clearing.
// done is high for one cycle only and result holds; busy drops the cycle it is shown.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top #(
	parameter int HEAP_BYTES = 65536,
	parameter int MAX_BLOCKS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ffba_pkg::request_t request,
	output logic               done,
	output ffba_pkg::result_t  result,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_wdata
);
	import ffba_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam logic [16:0] HEAP_MAX = 17'(HEAP_BYTES);

	fsm_e state_q, state_d;

	logic [6:0]  hdr_cfg_q;
	logic [7:0]  msplit_q;
	logic [16:0] limit_q;
	logic [6:0]  hdr;
	logic [16:0] lim;

	logic [MAX_BLOCKS-1:0] used_q;
	logic [IW-1:0]  head_q, cur_q, tail_q, tgt_q, sp_q;
	logic [6:0]     len_q, k_q;
	logic [16:0]    heap_end_q, alloc_q, res_q;
	status_e        st_q;
	request_t       req_q;
	entry_t         ent_q, tail_ent_q;
	logic           move_q, shrink_q;

	logic           we;
	logic [IW-1:0]  waddr, raddr;
	entry_t         wdata, rdata;

	logic           free_found;
	logic [IW-1:0]  free_idx;
	logic [18:0]    app_end;
	logic           fits, split_ok, co_merge;
	entry_t         merged;
	logic [IW-1:0]  nidx;

	ffba_table #(.DEPTH(MAX_BLOCKS), .IW(IW)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign hdr = (hdr_cfg_q == 7'd0) ? 7'd1 : hdr_cfg_q;
	assign lim = (limit_q < HEAP_MAX) ? limit_q : HEAP_MAX;
	assign busy = (state_q != FSM_IDLE);
	assign app_end = 19'(heap_end_q) + 19'(hdr) + 19'(req_q.request_size);
	assign fits = rdata.is_free && (rdata.size >= req_q.request_size);
	assign split_ok = (19'(ent_q.size) > 19'(req_q.request_size) + 19'(hdr) + 19'(msplit_q))
		&& free_found;
	assign nidx = ent_q.next[IW-1:0];
	assign co_merge = ent_q.is_free && rdata.is_free &&
		(19'(ent_q.offset) + 19'(hdr) + 19'(ent_q.size) == 19'(rdata.offset));

	always_comb begin
		merged = ent_q;
		merged.size = 17'(ent_q.size + 17'(hdr) + rdata.size);
		merged.next = rdata.next;
	end

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cfg_q <= HEADER_RESET;
			msplit_q <= MIN_SPLIT_RESET;
			limit_q <= HEAP_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_HEADER:     hdr_cfg_q <= cfg_wdata[6:0];
				REG_MIN_SPLIT:  msplit_q <= cfg_wdata[7:0];
				REG_HEAP_LIMIT: limit_q <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and table port control
	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = sp_q;
		wdata = ent_q;
		raddr = cur_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (start) state_d = FSM_DISP;
			end
			FSM_DISP: begin
				unique case (req_q.command)
					CMD_ALLOC: state_d = (req_q.request_size == 17'd0) ? FSM_FINISH : FSM_AL_RD;
					CMD_FREE: state_d = (req_q.payload_address == 17'd0) ? FSM_FINISH : FSM_FD_RD;
					CMD_REALLOC: begin
						if (req_q.payload_address != 17'd0) state_d = FSM_FD_RD;
						else if (req_q.request_size == 17'd0) state_d = FSM_FINISH;
						else state_d = FSM_AL_RD;
					end
					default: state_d = FSM_FINISH;
				endcase
			end
			FSM_AL_RD: begin
				if (k_q == len_q) begin
					state_d = FSM_AL_APP;
				end else begin
					state_d = FSM_AL_CHK;
				end
			end
			FSM_AL_CHK: begin
				state_d = fits ? FSM_SP_CHK : FSM_AL_RD;
			end
			FSM_AL_APP: begin
				if (app_end > 19'(lim) || !free_found) begin
					state_d = FSM_FINISH;
				end else begin
					we = 1'b1;
					waddr = free_idx;
					wdata = '{offset: heap_end_q[15:0], size: req_q.request_size,
						is_free: 1'b0, next: 6'd0};
					if (len_q != 7'd0) state_d = FSM_AL_TAIL;
					else state_d = move_q ? FSM_FR_RD : FSM_FINISH;
				end
			end
			FSM_AL_TAIL: begin
				we = 1'b1;
				waddr = tail_q;
				wdata = tail_ent_q;
				wdata.next = 6'(sp_q);
				state_d = move_q ? FSM_FR_RD : FSM_FINISH;
			end
			FSM_SP_CHK: begin
				we = 1'b1;
				if (split_ok) begin
					waddr = free_idx;
					wdata = '{offset: 16'(17'(ent_q.offset) + 17'(hdr) + req_q.request_size),
						size: 17'(ent_q.size - req_q.request_size - 17'(hdr)),
						is_free: 1'b1, next: ent_q.next};
					state_d = FSM_SP_WR2;
				end else begin
					state_d = (move_q && !shrink_q) ? FSM_FR_RD : FSM_FINISH;
				end
			end
			FSM_SP_WR2: begin
				we = 1'b1;
				state_d = (move_q && !shrink_q) ? FSM_FR_RD : FSM_FINISH;
			end
			FSM_FD_RD: begin
				state_d = (k_q == len_q) ? FSM_FINISH : FSM_FD_CHK;
			end
			FSM_FD_CHK: begin
				if (17'(rdata.offset) + 17'(hdr) == req_q.payload_address) begin
					if (rdata.is_free) state_d = FSM_FINISH;
					else if (req_q.command != CMD_REALLOC || req_q.request_size == 17'd0)
						state_d = FSM_FR_RD;
					else if (rdata.size >= req_q.request_size) state_d = FSM_SP_CHK;
					else state_d = FSM_AL_RD;
				end else begin
					state_d = FSM_FD_RD;
				end
			end
			FSM_FR_RD: begin
				raddr = tgt_q;
				state_d = FSM_FR_WR;
			end
			FSM_FR_WR: begin
				we = 1'b1;
				waddr = tgt_q;
				wdata = rdata;
				wdata.is_free = 1'b1;
				state_d = FSM_CO_RDH;
			end
			FSM_CO_RDH: begin
				raddr = head_q;
				state_d = FSM_CO_GETI;
			end
			FSM_CO_GETI: begin
				state_d = FSM_CO_LOOP;
			end
			FSM_CO_LOOP: begin
				raddr = nidx;
				if (8'(k_q) + 8'd1 >= 8'(len_q)) state_d = FSM_FINISH;
				else state_d = FSM_CO_CHK;
			end
			FSM_CO_CHK: begin
				if (co_merge) begin
					we = 1'b1;
					waddr = cur_q;
					wdata = merged;
				end
				state_d = FSM_CO_LOOP;
			end
			FSM_FINISH: begin
				state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// list state and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			head_q <= '0;
			len_q <= '0;
			heap_end_q <= '0;
			alloc_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				FSM_AL_APP: begin
					if (state_d != FSM_FINISH || (app_end <= 19'(lim) && free_found)) begin
						used_q[free_idx] <= 1'b1;
						len_q <= len_q + 7'd1;
						heap_end_q <= 17'(app_end);
						alloc_q <= alloc_q + req_q.request_size;
						if (len_q == 7'd0) head_q <= free_idx;
					end
				end
				FSM_SP_CHK: begin
					if (split_ok) begin
						used_q[free_idx] <= 1'b1;
						len_q <= len_q + 7'd1;
					end
					if (shrink_q) begin
						if (split_ok) alloc_q <= alloc_q + req_q.request_size - ent_q.size;
					end else begin
						alloc_q <= alloc_q + (split_ok ? req_q.request_size : ent_q.size);
					end
				end
				FSM_FR_WR: begin
					alloc_q <= alloc_q - rdata.size;
				end
				FSM_CO_CHK: begin
					if (co_merge) begin
						used_q[nidx] <= 1'b0;
						len_q <= len_q - 7'd1;
					end
				end
				FSM_FINISH: begin
					done <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			FSM_IDLE: begin
				req_q <= request;
			end
			FSM_DISP: begin
				cur_q <= head_q;
				k_q <= '0;
				move_q <= 1'b0;
				shrink_q <= 1'b0;
				res_q <= '0;
				st_q <= STAT_OK;
			end
			FSM_AL_CHK: begin
				if (fits) begin
					ent_q <= '{offset: rdata.offset, size: rdata.size,
						is_free: 1'b0, next: rdata.next};
					sp_q <= cur_q;
				end else begin
					tail_q <= cur_q;
					tail_ent_q <= rdata;
					cur_q <= rdata.next[IW-1:0];
					k_q <= k_q + 7'd1;
				end
			end
			FSM_AL_APP: begin
				if (app_end > 19'(lim) || !free_found) begin
					st_q <= STAT_NOMEM;
				end else begin
					sp_q <= free_idx;
					res_q <= 17'(heap_end_q[15:0]) + 17'(hdr);
				end
			end
			FSM_SP_CHK: begin
				res_q <= shrink_q ? req_q.payload_address : 17'(ent_q.offset) + 17'(hdr);
				if (split_ok) begin
					ent_q <= '{offset: ent_q.offset, size: req_q.request_size,
						is_free: ent_q.is_free, next: 6'(free_idx)};
				end
			end
			FSM_FD_CHK: begin
				if (17'(rdata.offset) + 17'(hdr) == req_q.payload_address) begin
					tgt_q <= cur_q;
					sp_q <= cur_q;
					ent_q <= rdata;
					if (rdata.is_free) begin
						st_q <= STAT_DBLFREE;
					end else if (req_q.command == CMD_REALLOC && req_q.request_size != 17'd0) begin
						if (rdata.size >= req_q.request_size) begin
							shrink_q <= 1'b1;
						end else begin
							move_q <= 1'b1;
							cur_q <= head_q;
							k_q <= '0;
						end
					end
				end else begin
					cur_q <= rdata.next[IW-1:0];
					k_q <= k_q + 7'd1;
				end
			end
			FSM_FD_RD: begin
				if (k_q == len_q) st_q <= STAT_UNKNOWN;
			end
			FSM_CO_RDH: begin
				cur_q <= head_q;
				k_q <= '0;
			end
			FSM_CO_GETI: begin
				ent_q <= rdata;
			end
			FSM_CO_CHK: begin
				if (co_merge) begin
					ent_q <= merged;
				end else begin
					cur_q <= nidx;
					ent_q <= rdata;
					k_q <= k_q + 7'd1;
				end
			end
			FSM_FINISH: begin
				result <= '{result_address: res_q, status: st_q,
					allocated_bytes: alloc_q, block_total: len_q};
			end
			default: ;
		endcase
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe held longer than one cycle");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= 7'(MAX_BLOCKS))
		else $error("block count beyond table depth");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item accepted without going busy");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit block allocator: a predictor of the
// block table answers each command, and every strobed result is compared
// field by field with the oldest prediction. Directed and table-full cases,
// then random alloc/free/realloc traffic over several register settings.
// ----------------------------------------------------------------------------
module tb;
	import ffba_pkg::*;

	localparam int HEAP = 65536;
	localparam int NBLK = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	request_t request = '0;
	logic done;
	result_t result;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [16:0] cfg_wdata = '0;

	first_fit_block_allocator_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state
	int unsigned hdr_r, split_r, lim_r;
	int unsigned b_off [NBLK];
	int unsigned b_sz [NBLK];
	bit b_free [NBLK];
	int unsigned b_nxt [NBLK];
	bit b_used [NBLK];
	int unsigned head, count, hend;

	result_t pending_results[$];
	int unsigned live_addrs[$];
	bit failed = 1'b0;
	bit calm = 1'b0;

	initial forever #2 clk = ~clk;

	initial begin
		#20000000;
		$display("FAIL first_fit_block_allocator_top");
		$finish;
	end

	function automatic int unsigned hsize();
		return hdr_r == 0 ? 1 : hdr_r;
	endfunction

	function automatic int unsigned hlim();
		return lim_r < HEAP ? lim_r : HEAP;
	endfunction

	function automatic int take_slot();
		for (int s = 0; s < NBLK; s++)
			if (!b_used[s]) begin
				b_used[s] = 1'b1;
				return s;
			end
		return -1;
	endfunction

	function automatic bit lookup(int unsigned a, output int unsigned at);
		int unsigned i;
		i = head;
		at = 0;
		for (int unsigned k = 0; k < count; k++) begin
			if (b_off[i] + hsize() == a) begin
				at = i;
				return 1'b1;
			end
			i = b_nxt[i] % NBLK;
		end
		return 1'b0;
	endfunction

	function automatic void carve(int unsigned i, int unsigned want);
		int s;
		if (b_sz[i] <= want + hsize() + split_r) return;
		s = take_slot();
		if (s < 0) return;
		b_off[s] = (b_off[i] + hsize() + want) & 16'hFFFF;
		b_sz[s] = (b_sz[i] - want - hsize()) & 17'h1FFFF;
		b_free[s] = 1'b1;
		b_nxt[s] = b_nxt[i];
		b_sz[i] = want;
		b_nxt[i] = s;
		count++;
	endfunction

	function automatic void merge_free();
		int unsigned i, k, n;
		i = head;
		k = 0;
		while (k + 1 < count) begin
			n = b_nxt[i] % NBLK;
			if (b_free[i] && b_free[n] && b_off[i] + hsize() + b_sz[i] == b_off[n]) begin
				b_sz[i] = (b_sz[i] + hsize() + b_sz[n]) & 17'h1FFFF;
				b_nxt[i] = b_nxt[n];
				b_used[n] = 1'b0;
				count--;
			end else begin
				i = n;
				k++;
			end
		end
	endfunction

	function automatic status_e grant(int unsigned sz, output int unsigned a);
		int unsigned i, tail, e;
		int s;
		i = head;
		tail = 0;
		a = 0;
		if (sz == 0) return STAT_OK;
		for (int unsigned k = 0; k < count; k++) begin
			if (b_free[i] && b_sz[i] >= sz) begin
				b_free[i] = 1'b0;
				carve(i, sz);
				a = (b_off[i] + hsize()) & 17'h1FFFF;
				return STAT_OK;
			end
			tail = i;
			i = b_nxt[i] % NBLK;
		end
		e = hend + hsize() + sz;
		if (e > hlim()) return STAT_NOMEM;
		s = take_slot();
		if (s < 0) return STAT_NOMEM;
		b_off[s] = hend & 16'hFFFF;
		b_sz[s] = sz;
		b_free[s] = 1'b0;
		b_nxt[s] = 0;
		if (count == 0) head = s;
		else b_nxt[tail] = s;
		count++;
		hend = e;
		a = (b_off[s] + hsize()) & 17'h1FFFF;
		return STAT_OK;
	endfunction

	function automatic status_e release_blk(int unsigned a);
		int unsigned i;
		if (a == 0) return STAT_OK;
		if (!lookup(a, i)) return STAT_UNKNOWN;
		if (b_free[i]) return STAT_DBLFREE;
		b_free[i] = 1'b1;
		merge_free();
		return STAT_OK;
	endfunction

	function automatic result_t heap_answer(request_t rq);
		result_t r;
		status_e st;
		int unsigned a, na, i, sum;
		a = 0;
		st = STAT_OK;
		case (cmd_e'(rq.command))
			CMD_ALLOC: st = grant(rq.request_size, a);
			CMD_FREE: st = release_blk(rq.payload_address);
			CMD_REALLOC: begin
				if (rq.payload_address == 0) st = grant(rq.request_size, a);
				else if (rq.request_size == 0) st = release_blk(rq.payload_address);
				else if (!lookup(rq.payload_address, i)) st = STAT_UNKNOWN;
				else if (b_free[i]) st = STAT_DBLFREE;
				else if (b_sz[i] >= rq.request_size) begin
					carve(i, rq.request_size);
					a = rq.payload_address;
				end else begin
					st = grant(rq.request_size, na);
					if (st == STAT_OK) begin
						b_free[i] = 1'b1;
						merge_free();
						a = na;
					end
				end
			end
			default: ;
		endcase
		sum = 0;
		i = head;
		for (int unsigned k = 0; k < count; k++) begin
			if (!b_free[i]) sum += b_sz[i];
			i = b_nxt[i] % NBLK;
		end
		r.result_address = 17'(a);
		r.status = st;
		r.allocated_bytes = 17'(sum);
		r.block_total = 7'(count);
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				if (result.result_address !== want.result_address) begin
					$display("%0t: address exp %h got %h", $time, want.result_address,
						result.result_address);
					failed = 1'b1;
				end
				if (result.status !== want.status) begin
					$display("%0t: status exp %h got %h", $time, want.status, result.status);
					failed = 1'b1;
				end
				if (result.allocated_bytes !== want.allocated_bytes) begin
					$display("%0t: allocated exp %h got %h", $time, want.allocated_bytes,
						result.allocated_bytes);
					failed = 1'b1;
				end
				if (result.block_total !== want.block_total) begin
					$display("%0t: blocks exp %h got %h", $time, want.block_total,
						result.block_total);
					failed = 1'b1;
				end
			end
		end
	end

	task automatic send_item(cmd_e c, int unsigned sz, int unsigned a);
		request_t rq;
		result_t r;
		rq.command = c;
		rq.request_size = 17'(sz);
		rq.payload_address = 17'(a);
		if (!calm && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 8)) @(posedge clk);
		start <= 1'b1;
		request <= rq;
		do @(posedge clk); while (busy);
		r = heap_answer(rq);
		pending_results.push_back(r);
		if (r.status == STAT_OK && r.result_address != 0)
			live_addrs.push_back(32'(r.result_address));
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(reg_e idx, int unsigned v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= 17'(v);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_HEADER: hdr_r = v & 7'h7F;
			REG_MIN_SPLIT: split_r = v & 8'hFF;
			REG_HEAP_LIMIT: lim_r = v & 17'h1FFFF;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic int unsigned pick_addr();
		if (live_addrs.size() == 0 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, 17'h1FFFF);
		return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
	endfunction

	task automatic test_directed();
		send_item(CMD_ALLOC, 0, 0);
		send_item(CMD_FREE, 0, 0);
		send_item(CMD_NONE, 17'h1FFFF, 17'h1FFFF);
		send_item(CMD_ALLOC, 100, 0);
		send_item(CMD_ALLOC, 40, 0);
		send_item(CMD_ALLOC, 17'h1FFFF, 0);
		send_item(CMD_FREE, 0, 17'h1FFFF);
		send_item(CMD_FREE, 0, 24);
		send_item(CMD_FREE, 0, 24);
		send_item(CMD_ALLOC, 20, 0);
		send_item(CMD_REALLOC, 10, 24);
		send_item(CMD_REALLOC, 500, 148);
		send_item(CMD_REALLOC, 30, 0);
		send_item(CMD_REALLOC, 0, 24);
		send_item(CMD_REALLOC, 5, 24);
		send_item(CMD_REALLOC, 5, 7);
		send_item(CMD_ALLOC, 65536, 0);
		send_item(CMD_ALLOC, 60000, 0);
		drain();
	endtask

	task automatic test_table_full();
		write_reg(REG_HEADER, 0);
		write_reg(REG_MIN_SPLIT, 0);
		write_reg(REG_HEAP_LIMIT, 17'h1FFFF);
		live_addrs.delete();
		for (int n = 0; n < 70; n++) send_item(CMD_ALLOC, 1, 0);
		send_item(CMD_FREE, 0, 2);
		send_item(CMD_ALLOC, 1, 0);
		drain();
	endtask

	task automatic test_random(int n, int unsigned maxsz);
		cmd_e c;
		int unsigned sz;
		for (int k = 0; k < n; k++) begin
			c = cmd_e'($urandom_range(0, 9) < 4 ? CMD_ALLOC :
				($urandom_range(0, 9) < 6 ? CMD_FREE :
				($urandom_range(0, 19) == 0 ? CMD_NONE : CMD_REALLOC)));
			sz = $urandom_range(0, 15) == 0 ? $urandom_range(0, 17'h1FFFF)
				: $urandom_range(0, maxsz);
			send_item(c, sz, pick_addr());
			if (k == n / 2) drain();
		end
		drain();
	endtask

	initial begin
		hdr_r = 32'(HEADER_RESET);
		split_r = 32'(MIN_SPLIT_RESET);
		lim_r = 32'(HEAP_LIMIT_RESET);
		head = 0;
		count = 0;
		hend = 0;
		for (int s = 0; s < NBLK; s++) b_used[s] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		write_reg(REG_HEADER, 64);
		write_reg(REG_MIN_SPLIT, 255);
		write_reg(REG_HEAP_LIMIT, 0);
		write_reg(REG_UNUSED, 5);
		test_random(60, 3000);
		write_reg(REG_HEAP_LIMIT, 30000);
		write_reg(REG_MIN_SPLIT, 0);
		test_random(350, 2000);
		write_reg(REG_HEADER, 1);
		write_reg(REG_HEAP_LIMIT, 65536);
		test_random(350, 1500);
		write_reg(REG_HEADER, 8);
		write_reg(REG_MIN_SPLIT, 16);
		calm = 1'b1;
		test_random(300, 1000);
		if (!failed) begin
			$display("PASS first_fit_block_allocator_top");
		end else begin
			$display("FAIL first_fit_block_allocator_top");
		end
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_table.sv
hw/rtl/first_fit_block_allocator_top.sv
sim/tb.sv
